>>> hdl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// Scaled decimal formatter package
// Shared constants, character codes and the converter control beat type.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int DEF_COEFF_BITS = 64;
  localparam int DEF_MAX_SCALE  = 28;
  localparam int DEF_MAX_DIGITS = 20;

  localparam int COEFF_IN_W = 64;
  localparam int SCALE_IN_W = 5;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;

  // A number never produces more than this many characters.
  localparam int MAX_CHARS = 31;
  localparam int POS_W     = 5;

  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

  typedef struct packed {
    logic start;
    logic pop;
  } conv_ctrl_t;

endpackage

>>> hdl/scaled_decimal_formatter_core.sv
// ----------------------------------------------------------------------------
// Scaled decimal formatter core
// Turns sign, scale and coefficient into ASCII text, one character per beat.
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   in       in_valid_i/in_stall_o   is_negative_i, scale_i, coefficient_i
//   out      out_valid_o/out_stall_i out_char_o, last_char_o
//
// An item passes through an accept step, bit-serial conversion of COEFF_BITS
// bits, stripping of up to MAX_DIGITS-1 leading zeros plus a step to end the
// scan, a handoff step, then one character per cycle while the output is not
// stalled (at most 31 characters).
// Reset is asynchronous and clears all control state; no clearing pass.
// Output stalls hold the character register and pause the character sequence.
// ----------------------------------------------------------------------------
module scaled_decimal_formatter_core #(
  parameter int COEFF_BITS = sdf_pkg::DEF_COEFF_BITS,
  parameter int MAX_SCALE  = sdf_pkg::DEF_MAX_SCALE,
  parameter int MAX_DIGITS = sdf_pkg::DEF_MAX_DIGITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             is_negative_i,
  input  logic [sdf_pkg::SCALE_IN_W-1:0]   scale_i,
  input  logic [sdf_pkg::COEFF_IN_W-1:0]   coefficient_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sdf_pkg::CHAR_W-1:0]       out_char_o,
  output logic                             last_char_o
);
  import sdf_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int SC_W  = $clog2(MAX_SCALE + 1);
  localparam int CMP_W = ((CNT_W > SC_W) ? CNT_W : SC_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT,
    S_SIGN,
    S_LEAD,
    S_LPOINT,
    S_LZERO,
    S_INT,
    S_POINT,
    S_FRAC
  } state_e;

  state_e              state_q;
  logic                neg_q;
  logic [SC_W-1:0]     sc_q;
  logic [CNT_W-1:0]    dl_q;
  logic [SC_W-1:0]     zl_q;
  logic [POS_W-1:0]    pos_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                last_q;

  conv_ctrl_t          conv_ctrl;
  logic                conv_done;
  logic [DIGIT_W-1:0]  conv_digit;
  logic [CNT_W-1:0]    conv_count;

  logic                in_accept;
  logic [SC_W-1:0]     sc_clamp;
  logic [CMP_W-1:0]    cnt_e;
  logic [CMP_W-1:0]    sc_e;
  state_e              body_state;
  logic [CNT_W-1:0]    body_dl;
  logic [SC_W-1:0]     body_zl;

  logic                emitting;
  logic                emit_go;
  logic [CHAR_W-1:0]   emit_char;
  state_e              emit_next;
  logic [CNT_W-1:0]    dl_next;
  logic [SC_W-1:0]     zl_next;
  logic                fin;
  logic                pop_c;
  logic                emit_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sc_clamp = (32'(scale_i) > 32'(MAX_SCALE)) ? SC_W'(MAX_SCALE) : SC_W'(scale_i);

  assign conv_ctrl.start = in_accept;
  assign conv_ctrl.pop   = emit_go && pop_c;

  sdf_bcd_conv #(
    .COEFF_BITS(COEFF_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (conv_ctrl),
    .coeff_i(coefficient_i[COEFF_BITS-1:0]),
    .done_o (conv_done),
    .digit_o(conv_digit),
    .count_o(conv_count)
  );

  // Layout of the text after the optional sign.
  always_comb begin
    cnt_e   = CMP_W'(conv_count);
    sc_e    = CMP_W'(sc_q);
    body_zl = '0;
    if (sc_q == '0) begin
      body_state = S_INT;
      body_dl    = conv_count;
    end else if (cnt_e <= sc_e) begin
      body_state = S_LEAD;
      body_dl    = conv_count;
      body_zl    = SC_W'(sc_e - cnt_e);
    end else begin
      body_state = S_INT;
      body_dl    = CNT_W'(cnt_e - sc_e);
    end
  end

  assign emitting = (state_q != S_IDLE) && (state_q != S_WAIT);
  assign emit_go  = emitting && (!out_valid_q || !out_stall_i);

  always_comb begin
    emit_char = CH_ZERO;
    emit_next = state_q;
    dl_next   = dl_q;
    zl_next   = zl_q;
    fin       = 1'b0;
    pop_c     = 1'b0;
    case (state_q)
      S_SIGN: begin
        emit_char = CH_MINUS;
        emit_next = body_state;
      end
      S_LEAD: begin
        emit_next = S_LPOINT;
      end
      S_LPOINT: begin
        emit_char = CH_POINT;
        emit_next = (zl_q == '0) ? S_FRAC : S_LZERO;
      end
      S_LZERO: begin
        zl_next = zl_q - SC_W'(1);
        if (zl_q == SC_W'(1)) begin
          emit_next = S_FRAC;
        end
      end
      S_INT: begin
        emit_char = CH_ZERO + {2'b00, conv_digit};
        pop_c     = 1'b1;
        dl_next   = dl_q - CNT_W'(1);
        if (dl_q == CNT_W'(1)) begin
          if (sc_q == '0) begin
            fin = 1'b1;
          end else begin
            emit_next = S_POINT;
          end
        end
      end
      S_POINT: begin
        emit_char = CH_POINT;
        dl_next   = CNT_W'(sc_q);
        emit_next = S_FRAC;
      end
      S_FRAC: begin
        emit_char = CH_ZERO + {2'b00, conv_digit};
        pop_c     = 1'b1;
        dl_next   = dl_q - CNT_W'(1);
        if (dl_q == CNT_W'(1)) begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The text is cut at its maximum length, and the cut character is the last.
  assign emit_last = fin || (pos_q == POS_W'(MAX_CHARS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      sc_q        <= '0;
      dl_q        <= '0;
      zl_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= CH_ZERO;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            neg_q   <= is_negative_i;
            sc_q    <= sc_clamp;
            pos_q   <= '0;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (conv_done) begin
            dl_q    <= body_dl;
            zl_q    <= body_zl;
            state_q <= neg_q ? S_SIGN : body_state;
          end
        end
        default: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            out_char_q  <= emit_char;
            last_q      <= emit_last;
            pos_q       <= pos_q + POS_W'(1);
            dl_q        <= dl_next;
            zl_q        <= zl_next;
            state_q     <= emit_last ? S_IDLE : emit_next;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting |-> (pos_q <= POS_W'(MAX_CHARS - 1)))
    else $error("character position ran past the maximum text length");

  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT || state_q == S_FRAC) |-> (dl_q != '0))
    else $error("digit phase entered with no digits left");

  a_mid_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_char_o) |-> emitting)
    else $error("text sequence stopped before its last character");
`endif

endmodule

>>> hdl/sdf_bcd_conv.sv
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shift-add-3 conversion one coefficient bit per cycle, then a leading zero
// strip one digit per cycle. Digits are then popped most significant first.
// ----------------------------------------------------------------------------
module sdf_bcd_conv #(
  parameter int COEFF_BITS = sdf_pkg::DEF_COEFF_BITS,
  parameter int MAX_DIGITS = sdf_pkg::DEF_MAX_DIGITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sdf_pkg::conv_ctrl_t             ctrl_i,
  input  logic [COEFF_BITS-1:0]           coeff_i,
  output logic                            done_o,
  output logic [sdf_pkg::DIGIT_W-1:0]     digit_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0] count_o
);
  import sdf_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;
  localparam int BIT_W = $clog2(COEFF_BITS + 1);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    C_IDLE,
    C_CONV,
    C_SCAN,
    C_HOLD
  } cstate_e;

  cstate_e              state_q;
  logic [BIT_W-1:0]     bit_cnt_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 ovf_q;
  logic [COEFF_BITS-1:0] coef_q;
  logic [BCD_W-1:0]     bcd_q;
  logic [BCD_W-1:0]     adj;
  logic [DIGIT_W-1:0]   dig_v;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 strip;

  // Each digit is corrected on its own before the shift.
  always_comb begin
    dig_v = '0;
    for (int g = 0; g < MAX_DIGITS; g++) begin
      dig_v = bcd_q[g*DIGIT_W +: DIGIT_W];
      adj[g*DIGIT_W +: DIGIT_W] = (dig_v >= 4'd5) ? dig_v + 4'd3 : dig_v;
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
  // An overflowed value keeps all of its low digits, zeros included.
  assign strip = !ovf_q && (top_digit == '0) && (cnt_q > CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      bit_cnt_q <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      case (state_q)
        C_CONV: begin
          ovf_q     <= ovf_q | adj[BCD_W-1];
          bit_cnt_q <= bit_cnt_q - BIT_W'(1);
          if (bit_cnt_q == BIT_W'(1)) begin
            state_q <= C_SCAN;
            cnt_q   <= CNT_W'(MAX_DIGITS);
          end
        end
        C_SCAN: begin
          if (strip) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end else begin
            state_q <= C_HOLD;
          end
        end
        default: ;
      endcase
      if (ctrl_i.start) begin
        state_q   <= C_CONV;
        bit_cnt_q <= BIT_W'(COEFF_BITS);
        ovf_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      coef_q <= coeff_i;
      bcd_q  <= '0;
    end else if (state_q == C_CONV) begin
      coef_q <= {coef_q[COEFF_BITS-2:0], 1'b0};
      bcd_q  <= {adj[BCD_W-2:0], coef_q[COEFF_BITS-1]};
    end else if ((state_q == C_SCAN && strip) || (state_q == C_HOLD && ctrl_i.pop)) begin
      bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign done_o  = (state_q == C_HOLD);
  assign digit_o = top_digit;
  assign count_o = cnt_q;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scaled decimal formatter testbench
// Sends sign, scale and coefficient items into the formatter core. It works
// out the expected ASCII text of every accepted item and checks each output
// beat in order, with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sdf_pkg::*;

  localparam int NUM_RANDOM  = 187;
  localparam int DRAIN_AT    = 40;   // offer index at which the sender waits for the text
  localparam int HOLD_AT     = 80;   // accepted count that starts the long hold-off
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 150;

  typedef struct packed {
    logic                  neg;
    logic [SCALE_IN_W-1:0] scale;
    logic [COEFF_IN_W-1:0] coeff;
  } number_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  logic                  is_negative = 1'b0;
  logic [SCALE_IN_W-1:0] scale = '0;
  logic [COEFF_IN_W-1:0] coefficient = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_char_o;
  logic                  last_char_o;

  number_t    numbers_q[$];
  char_beat_t text_q[$];
  number_t    offered;
  char_beat_t want;
  int         n_offered = 0;
  int         n_accepted = 0;
  int         n_errors = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       calm;

  scaled_decimal_formatter_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .is_negative_i(is_negative),
    .scale_i      (scale),
    .coefficient_i(coefficient),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o)
  );

  always #4 clk_i = ~clk_i;

  // Neither side idles while this window of items goes through.
  assign calm = (n_accepted >= 110) && (n_accepted < 150);

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return CH_ZERO + {2'b00, d};
  endfunction

  // Appends the text of one number to the expected beats.
  function automatic void predict_text(input number_t num);
    logic [DIGIT_W-1:0] digs [DEF_MAX_DIGITS];
    logic [CHAR_W-1:0]  txt [$];
    logic [COEFF_IN_W-1:0] c;
    int ndig;
    int sc;
    sc = (num.scale > DEF_MAX_SCALE) ? DEF_MAX_SCALE : int'(num.scale);
    c = num.coeff;
    ndig = 0;
    digs[0] = '0;
    if (c == 0) ndig = 1;
    while (c != 0 && ndig < DEF_MAX_DIGITS) begin
      digs[ndig] = DIGIT_W'(c % 10);
      ndig++;
      c = c / 10;
    end
    if (num.neg) txt.push_back(CH_MINUS);
    if (sc == 0) begin
      for (int i = ndig - 1; i >= 0; i--) txt.push_back(digit_char(digs[i]));
    end else if (ndig <= sc) begin
      txt.push_back(CH_ZERO);
      txt.push_back(CH_POINT);
      repeat (sc - ndig) txt.push_back(CH_ZERO);
      for (int i = ndig - 1; i >= 0; i--) txt.push_back(digit_char(digs[i]));
    end else begin
      for (int i = ndig - 1; i >= sc; i--) txt.push_back(digit_char(digs[i]));
      txt.push_back(CH_POINT);
      for (int i = sc - 1; i >= 0; i--) txt.push_back(digit_char(digs[i]));
    end
    foreach (txt[i]) text_q.push_back({txt[i], i == txt.size() - 1});
  endfunction

  // Mixes full-width values with small ones and values next to powers of ten,
  // which sit at the edges of the digit count.
  function automatic logic [COEFF_IN_W-1:0] rand_coefficient();
    logic [COEFF_IN_W-1:0] p;
    int k;
    p = 64'd1;
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 999));
      2: begin
        k = $urandom_range(0, 19);
        repeat (k) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      3: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Sender: a beat stays on the bus until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_text(offered);
        n_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (numbers_q.size() != 0 && (calm || $urandom_range(0, 99) >= 11) &&
            !(n_offered == DRAIN_AT && text_q.size() != 0)) begin
          offered = numbers_q.pop_front();
          is_negative <= offered.neg;
          scale       <= offered.scale;
          coefficient <= offered.coeff;
          in_valid    <= 1'b1;
          n_offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < 11);
    end
  end

  // Monitor: every output beat is matched against the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (text_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected beat: char %0d last %0b", out_char_o, last_char_o);
      end else begin
        want = text_q.pop_front();
        if (out_char_o !== want.ch || last_char_o !== want.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                     want.ch, want.last, out_char_o, last_char_o);
        end
      end
    end
  end

  initial begin
    numbers_q.push_back({1'b0, 5'd0, 64'd0});
    numbers_q.push_back({1'b1, 5'd0, 64'd0});
    numbers_q.push_back({1'b0, 5'd2, 64'd0});
    // Negative zero at the largest scale gives the longest text.
    numbers_q.push_back({1'b1, 5'd28, 64'd0});
    numbers_q.push_back({1'b0, 5'd31, 64'd0});
    numbers_q.push_back({1'b0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    numbers_q.push_back({1'b1, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    numbers_q.push_back({1'b1, 5'd28, 64'hFFFF_FFFF_FFFF_FFFF});
    numbers_q.push_back({1'b0, 5'd19, 64'hFFFF_FFFF_FFFF_FFFF});
    numbers_q.push_back({1'b0, 5'd20, 64'hFFFF_FFFF_FFFF_FFFF});
    numbers_q.push_back({1'b0, 5'd29, 64'd12345});
    numbers_q.push_back({1'b1, 5'd30, 64'd1});
    numbers_q.push_back({1'b0, 5'd31, 64'd999});
    numbers_q.push_back({1'b0, 5'd5, 64'd12345});
    numbers_q.push_back({1'b0, 5'd4, 64'd12345});
    numbers_q.push_back({1'b0, 5'd1, 64'd1});
    numbers_q.push_back({1'b1, 5'd1, 64'd10000000000000000000});
    numbers_q.push_back({1'b0, 5'd0, 64'd9});
    numbers_q.push_back({1'b0, 5'd1, 64'd10});
    numbers_q.push_back({1'b1, 5'd3, 64'hAAAA_AAAA_AAAA_AAAA});
    numbers_q.push_back({1'b0, 5'd17, 64'h5555_5555_5555_5555});
    numbers_q.push_back({1'b0, 5'd16, 64'd9999999999999999999});
    numbers_q.push_back({1'b1, 5'd0, 64'd1});
    repeat (NUM_RANDOM)
      numbers_q.push_back({1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                           rand_coefficient()});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_q.size() != 0 || in_valid) @(posedge clk_i);
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && text_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
